[design/swr_pkg.sv]
package swr_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int SEQ_W      = 32;
   localparam int CSR_W      = 6;
   localparam int CNT_W      = 6;
   localparam int EWIN_W     = $clog2(MAX_WINDOW + 1);
   localparam int OFS_W      = $clog2(MAX_WINDOW);

   localparam logic [SEQ_W-1:0] SEQ_MAX     = '1;
   localparam logic [CSR_W-1:0] WINDOW_RESET = CSR_W'(32);

   typedef enum logic [1:0] {
      VERDICT_DROP = 2'd0,
      VERDICT_ACK  = 2'd1,
      VERDICT_NAK  = 2'd2
   } verdict_type;

   typedef struct packed {
      logic shift;
      logic set;
   } cell_ctrl_type;

endpackage

[design/sliding_window_receiver.sv]
// Selective-repeat sliding-window receiver.
// Request channel (req_valid / req_stall / req_frame_seq): one transaction per
// arriving frame sequence number. Response channel (rsp_valid / rsp_stall /
// rsp_verdict / rsp_reply_seq / rsp_released_count): exactly one transaction
// per request: discard, cumulative ACK or NAK of the next expected number.
// Configuration: csr_wr_en writes csr_window_size (0 acts as 1, values above
// the maximum window act as the maximum); write only while idle.
// Received marks sit in a row of cells; cell 0 stands for the next expected
// frame. Release shifts the row down by one cell per cycle.
// Flow: a discarded frame goes from IDLE to DONE; an accepted frame goes from
// IDLE to SCAN, which releases n frames (0 to 32), then to DONE, where the
// response waits for the output register. req_stall is high from acceptance
// until the response is loaded into the output register. A new request is
// taken while the previous response still waits on rsp_stall; its response
// waits in turn for the output register.
// Reset (synchronous, active high) clears all marks, the last in-order
// number, and sets the window to 32.
module sliding_window_receiver (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [swr_pkg::CSR_W-1:0]   csr_window_size,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [swr_pkg::SEQ_W-1:0]   req_frame_seq,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_verdict,
   output logic [swr_pkg::SEQ_W-1:0]   rsp_reply_seq,
   output logic [swr_pkg::CNT_W-1:0]   rsp_released_count
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [swr_pkg::CSR_W-1:0]      window_ff, window_in;
   logic [swr_pkg::SEQ_W-1:0]      last_ff, last_in;
   logic [swr_pkg::EWIN_W-1:0]     num_ff, num_in;
   logic                           drop_ff, drop_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   swr_pkg::verdict_type           rsp_verdict_ff, rsp_verdict_in;
   logic [swr_pkg::SEQ_W-1:0]      rsp_reply_ff, rsp_reply_in;
   logic [swr_pkg::CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [swr_pkg::EWIN_W-1:0]     eff_win;
   logic [swr_pkg::SEQ_W-1:0]      diff;
   logic [swr_pkg::OFS_W-1:0]      offset;
   logic                           accept;
   logic                           in_window;
   logic                           scan_go;
   logic                           out_free;
   logic [swr_pkg::MAX_WINDOW-1:0] marks;

   always_comb begin
      if (window_ff == '0) begin
         eff_win = swr_pkg::EWIN_W'(1);
      end else if (32'(window_ff) > 32'(swr_pkg::MAX_WINDOW)) begin
         eff_win = swr_pkg::EWIN_W'(swr_pkg::MAX_WINDOW);
      end else begin
         eff_win = swr_pkg::EWIN_W'(window_ff);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign diff      = req_frame_seq - last_ff;
   assign in_window = (req_frame_seq > last_ff) && (diff <= swr_pkg::SEQ_W'(eff_win));
   assign offset    = swr_pkg::OFS_W'(diff - swr_pkg::SEQ_W'(1));
   assign scan_go   = (state_ff == SCAN) && marks[0] && (num_ff < eff_win) &&
                      (last_ff != swr_pkg::SEQ_MAX);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   for (genvar i = 0; i < swr_pkg::MAX_WINDOW; i++) begin : g_cell
      swr_pkg::cell_ctrl_type ctrl;
      logic                   next_mark;

      assign ctrl.shift = scan_go;
      assign ctrl.set   = accept && in_window && (offset == swr_pkg::OFS_W'(i));

      if (i == swr_pkg::MAX_WINDOW - 1) begin : g_tail
         assign next_mark = 1'b0;
      end else begin : g_body
         assign next_mark = marks[i+1];
      end

      swr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .next_mark (next_mark),
         .mark      (marks[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      window_in      = csr_wr_en ? csr_window_size : window_ff;
      last_in        = last_ff;
      num_in         = num_ff;
      drop_in        = drop_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_reply_in   = rsp_reply_ff;
      rsp_count_in   = rsp_count_ff;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               num_in  = '0;
               drop_in = !in_window;
               state_in = in_window ? SCAN : DONE;
            end
         end
         SCAN: begin
            if (scan_go) begin
               last_in = last_ff + swr_pkg::SEQ_W'(1);
               num_in  = num_ff + swr_pkg::EWIN_W'(1);
            end else begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (drop_ff) begin
                  rsp_verdict_in = swr_pkg::VERDICT_DROP;
                  rsp_reply_in   = '0;
                  rsp_count_in   = '0;
               end else begin
                  if (num_ff == '0 && last_ff != '0) begin
                     rsp_verdict_in = swr_pkg::VERDICT_NAK;
                  end else begin
                     rsp_verdict_in = swr_pkg::VERDICT_ACK;
                  end
                  if (last_ff == swr_pkg::SEQ_MAX) begin
                     rsp_reply_in = swr_pkg::SEQ_MAX;
                  end else begin
                     rsp_reply_in = last_ff + swr_pkg::SEQ_W'(1);
                  end
                  rsp_count_in = swr_pkg::CNT_W'(num_ff);
               end
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         window_ff    <= swr_pkg::WINDOW_RESET;
         last_ff      <= '0;
         num_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         last_ff      <= last_in;
         num_ff       <= num_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_reply_ff   <= rsp_reply_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_stall          = (state_ff != IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_reply_seq      = rsp_reply_ff;
   assign rsp_released_count = rsp_count_ff;

endmodule

[design/swr_cell.sv]
module swr_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  swr_pkg::cell_ctrl_type ctrl,
   input  logic                   next_mark,
   output logic                   mark
);

   logic mark_ff;
   logic mark_in;

   always_comb begin
      if (ctrl.shift) begin
         mark_in = next_mark;
      end else begin
         mark_in = mark_ff | ctrl.set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   assign mark = mark_ff;

endmodule
